FILE: hdl/wgs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the weighted graph store.
// No dependencies; every other file in hdl/ but wgs_matrix_ram imports this package.
package wgs_pkg;

	// Sizes of the node table and of the weight matrix.
	localparam int MAX_NODES = 16;
	localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CELL_AW   = 2 * NODE_W;
	localparam int CELLS     = 1 << CELL_AW;

	// Field widths of the item ports.
	localparam int ID_W    = 32;
	localparam int WT_W    = 32;
	localparam int REQ_W   = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Request codes carried by req_type.
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD        = 3'd0,
		REQ_REMOVE     = 3'd1,
		REQ_CONNECT    = 3'd2,
		REQ_QUERY      = 3'd3,
		REQ_DISCONNECT = 3'd4,
		REQ_REWEIGHT   = 3'd5
	} req_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_APPLIED = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Sequencer states of the top level.
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_READ,
		S_EXEC,
		S_SWEEP,
		S_POST,
		S_PREAD,
		S_DONE
	} state_t;

	// Result of matching node_a and node_b against the slot table.
	typedef struct packed {
		logic              a_hit;
		logic [NODE_W-1:0] sa;
		logic              b_hit;
		logic [NODE_W-1:0] sb;
		logic              full;
		logic [NODE_W-1:0] free_slot;
	} lookup_t;

	// Slot table update: fill a slot with node_a, or release a slot.
	typedef struct packed {
		logic              set;
		logic              clr;
		logic [NODE_W-1:0] slot;
	} slot_cmd_t;

endpackage

FILE: hdl/wgs_matrix_ram.sv
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM that holds the weight matrix.
// Read data is registered; no package dependencies.
module wgs_matrix_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/wgs_slot_table.sv
`timescale 1ns / 1ps
// Node slot table: IDs and valid marks, with parallel matching of two IDs.
// Depends on wgs_pkg for sizes and the lookup and command structs.
module wgs_slot_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [wgs_pkg::ID_W-1:0] node_a,
	input  logic [wgs_pkg::ID_W-1:0] node_b,
	input  wgs_pkg::slot_cmd_t      cmd,
	output wgs_pkg::lookup_t        look
);
	import wgs_pkg::*;

	logic [ID_W-1:0]      ids_q [MAX_NODES];
	logic [MAX_NODES-1:0] valid_q;
	logic [MAX_NODES-1:0] hit_a;
	logic [MAX_NODES-1:0] hit_b;

	// Valid marks clear at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.set) begin
			valid_q[cmd.slot] <= 1'b1;
		end else if (cmd.clr) begin
			valid_q[cmd.slot] <= 1'b0;
		end
	end

	// IDs are only looked at while their slot is valid.
	always_ff @(posedge clk) begin
		if (cmd.set) begin
			ids_q[cmd.slot] <= node_a;
		end
	end

	// Compare both IDs against every valid slot.
	always_comb begin
		for (int s = 0; s < MAX_NODES; s++) begin
			hit_a[s] = valid_q[s] && (ids_q[s] == node_a);
			hit_b[s] = valid_q[s] && (ids_q[s] == node_b);
		end
	end

	// The lowest matching slot wins, and the lowest free slot is offered for an add.
	always_comb begin
		look.a_hit     = |hit_a;
		look.b_hit     = |hit_b;
		look.full      = &valid_q;
		look.sa        = '0;
		look.sb        = '0;
		look.free_slot = '0;
		for (int s = MAX_NODES - 1; s >= 0; s--) begin
			if (hit_a[s]) begin
				look.sa = NODE_W'(s);
			end
			if (hit_b[s]) begin
				look.sb = NODE_W'(s);
			end
			if (!valid_q[s]) begin
				look.free_slot = NODE_W'(s);
			end
		end
	end

endmodule

FILE: hdl/weighted_graph_store.sv
`timescale 1ns / 1ps
// Top level of the weighted graph store: request sequencer and result register.
// Depends on wgs_pkg, wgs_slot_table and wgs_matrix_ram.
//
//  Channel   Handshake             Payload
//  -------   -------------------   ------------------------------------------------
//  in        in_valid / in_ready   req_type, node_a, node_b, edge_weight
//  out       out_valid / out_ready status, a_present, linked, weight_out, node_count
//
// One item is worked on at a time. Query, connect, disconnect and reweight go through
// LOOK, READ, EXEC, POST, PREAD and DONE before the next acceptance; add and remove also
// clear MAX_NODES matrix entries in SWEEP, one entry per cycle through the write port of
// the matrix RAM. After reset all 2^(2*ceil(log2 MAX_NODES)) matrix entries (256 for
// 16 nodes) are swept to zero with in_ready low. A result waiting on out_ready holds in
// the output register; the block then stalls only before loading the next result.
module weighted_graph_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [wgs_pkg::REQ_W-1:0]   req_type,
	input  logic [wgs_pkg::ID_W-1:0]    node_a,
	input  logic [wgs_pkg::ID_W-1:0]    node_b,
	input  logic [wgs_pkg::WT_W-1:0]    edge_weight,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wgs_pkg::STAT_W-1:0]  status,
	output logic                        a_present,
	output logic                        linked,
	output logic [wgs_pkg::WT_W-1:0]    weight_out,
	output logic [wgs_pkg::COUNT_W-1:0] node_count
);
	import wgs_pkg::*;

	// Control state.
	state_t               state_q;
	state_t               state_d;
	logic [CELL_AW-1:0]   clr_q;
	logic [NODE_W-1:0]    sweep_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 out_valid_q;

	// Request and working registers.
	req_t                 req_q;
	logic [ID_W-1:0]      a_q;
	logic [ID_W-1:0]      b_q;
	logic [WT_W-1:0]      w_q;
	lookup_t              look_q;
	status_t              status_q;
	logic [NODE_W-1:0]    sweep_slot_q;
	logic                 sweep_col_q;

	// Output register.
	status_t              out_status_q;
	logic                 out_a_present_q;
	logic                 out_linked_q;
	logic [WT_W-1:0]      out_weight_q;
	logic [COUNT_W-1:0]   out_count_q;

	// Slot table and matrix connections.
	lookup_t              look;
	slot_cmd_t            slot_cmd;
	logic                 mem_we;
	logic [CELL_AW-1:0]   mem_waddr;
	logic [WT_W-1:0]      mem_wdata;
	logic [CELL_AW-1:0]   mem_raddr;
	logic [WT_W-1:0]      mem_rdata;

	// Decision made when the addressed cell has been read.
	status_t              exec_status;
	logic                 exec_we;
	logic [WT_W-1:0]      exec_wdata;
	logic                 exec_set;
	logic                 exec_clr;
	logic                 exec_sweep;
	logic                 both_hit;
	logic                 sweep_last;
	logic                 look_ld;
	logic                 out_ld;
	logic [WT_W-1:0]      result_wt;

	wgs_slot_table u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.node_a (a_q),
		.node_b (b_q),
		.cmd    (slot_cmd),
		.look   (look)
	);

	wgs_matrix_ram #(
		.DEPTH (CELLS),
		.WIDTH (WT_W)
	) u_matrix (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign both_hit   = look_q.a_hit && look_q.b_hit;
	assign sweep_last = (sweep_q == NODE_W'(MAX_NODES - 1));
	assign result_wt  = both_hit ? mem_rdata : '0;

	// Apply the request to the looked-up slots and the cell read from the matrix.
	// Removal clears the column of the slot; an add clears the row of the new slot.
	always_comb begin
		exec_status = ST_IGNORED;
		exec_we     = 1'b0;
		exec_wdata  = '0;
		exec_set    = 1'b0;
		exec_clr    = 1'b0;
		exec_sweep  = 1'b0;
		unique case (req_q)
			REQ_ADD: begin
				if (look_q.a_hit) begin
					exec_status = ST_IGNORED;
				end else if (look_q.full) begin
					exec_status = ST_FULL;
				end else begin
					exec_status = ST_APPLIED;
					exec_set    = 1'b1;
					exec_sweep  = 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (look_q.a_hit) begin
					exec_status = ST_APPLIED;
					exec_clr    = 1'b1;
					exec_sweep  = 1'b1;
				end
			end
			REQ_CONNECT: begin
				if (both_hit && (w_q != '0)) begin
					exec_status = ST_APPLIED;
					exec_we     = 1'b1;
					exec_wdata  = w_q;
				end
			end
			REQ_QUERY: begin
				exec_status = ST_APPLIED;
			end
			REQ_DISCONNECT: begin
				if (both_hit && (mem_rdata != '0)) begin
					exec_status = ST_APPLIED;
					exec_we     = 1'b1;
				end
			end
			REQ_REWEIGHT: begin
				if (both_hit && (mem_rdata != '0) && (w_q != '0)) begin
					exec_status = ST_APPLIED;
					exec_we     = 1'b1;
					exec_wdata  = w_q;
				end
			end
			default: begin
				exec_status = ST_IGNORED;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (&clr_q) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK:  state_d = S_READ;
			S_READ:  state_d = S_EXEC;
			S_EXEC:  state_d = exec_sweep ? S_SWEEP : S_POST;
			S_SWEEP: begin
				if (sweep_last) begin
					state_d = S_POST;
				end
			end
			S_POST:  state_d = S_PREAD;
			S_PREAD: state_d = S_DONE;
			S_DONE: begin
				if (out_ld) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Per-state outputs: memory port, slot command, lookup and result loads.
	always_comb begin
		in_ready      = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = {look_q.sa, look_q.sb};
		mem_wdata     = '0;
		mem_raddr     = {look_q.sa, look_q.sb};
		slot_cmd.set  = 1'b0;
		slot_cmd.clr  = 1'b0;
		slot_cmd.slot = exec_set ? look_q.free_slot : look_q.sa;
		look_ld       = 1'b0;
		out_ld        = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_LOOK, S_POST: begin
				look_ld = 1'b1;
			end
			S_EXEC: begin
				mem_we       = exec_we;
				mem_wdata    = exec_wdata;
				slot_cmd.set = exec_set;
				slot_cmd.clr = exec_clr;
			end
			S_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_col_q ? {sweep_q, sweep_slot_q} : {sweep_slot_q, sweep_q};
			end
			S_DONE: begin
				out_ld = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sweep_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_EXEC) begin
				sweep_q <= '0;
			end else if (state_q == S_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if ((state_q == S_EXEC) && exec_set) begin
				count_q <= count_q + 1'b1;
			end else if ((state_q == S_EXEC) && exec_clr) begin
				count_q <= count_q - 1'b1;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, lookup results and sweep target.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= req_t'(req_type);
			a_q   <= node_a;
			b_q   <= node_b;
			w_q   <= edge_weight;
		end
		if (look_ld) begin
			look_q <= look;
		end
		if (state_q == S_EXEC) begin
			status_q     <= exec_status;
			sweep_slot_q <= exec_set ? look_q.free_slot : look_q.sa;
			sweep_col_q  <= exec_clr;
		end
	end

	// Result register: state after the request, looked up again.
	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_status_q    <= status_q;
			out_a_present_q <= look_q.a_hit;
			out_linked_q    <= (result_wt != '0);
			out_weight_q    <= result_wt;
			out_count_q     <= count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign a_present  = out_a_present_q;
	assign linked     = out_linked_q;
	assign weight_out = out_weight_q;
	assign node_count = out_count_q;

endmodule

FILE: hdl/wgs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the weighted graph store, bound to the top level.
// Depends on wgs_pkg and on the port list of weighted_graph_store.
module wgs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [wgs_pkg::REQ_W-1:0]   req_type,
	input logic [wgs_pkg::ID_W-1:0]    node_a,
	input logic [wgs_pkg::ID_W-1:0]    node_b,
	input logic [wgs_pkg::WT_W-1:0]    edge_weight,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [wgs_pkg::STAT_W-1:0]  status,
	input logic                        a_present,
	input logic                        linked,
	input logic [wgs_pkg::WT_W-1:0]    weight_out,
	input logic [wgs_pkg::COUNT_W-1:0] node_count
);
	import wgs_pkg::*;

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(weight_out)
			&& $stable(node_count) && $stable(a_present) && $stable(linked))
		else $error("stalled result changed");

	// An edge is reported exactly when its weight is nonzero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (linked == (weight_out != '0)))
		else $error("linked disagrees with weight_out");

	// A full table is only reported with every slot taken and node_a absent.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (node_count == COUNT_W'(MAX_NODES)) && !a_present)
		else $error("full status with free slots or present node");

	// Items are taken one at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

endmodule

bind weighted_graph_store wgs_checker u_wgs_checker (.*);
